/* hdl/sbl_pkg.sv */
// Shared types and constants for the source byte lexer.
package sbl_pkg;

  typedef enum logic [3:0] {
    M_IDLE    = 4'd0,
    M_SLASH   = 4'd1,
    M_OP      = 4'd2,
    M_DOT     = 4'd3,
    M_INT     = 4'd4,
    M_NUMDOT  = 4'd5,
    M_FRAC    = 4'd6,
    M_IDENT   = 4'd7,
    M_STRING  = 4'd8,
    M_COMMENT = 4'd9
  } lex_mode_t;

  localparam logic [5:0] TK_EOF    = 6'd0;
  localparam logic [5:0] TK_LPAR   = 6'd1;
  localparam logic [5:0] TK_RPAR   = 6'd2;
  localparam logic [5:0] TK_LBRACE = 6'd3;
  localparam logic [5:0] TK_RBRACE = 6'd4;
  localparam logic [5:0] TK_PLUS   = 6'd5;
  localparam logic [5:0] TK_MINUS  = 6'd6;
  localparam logic [5:0] TK_STAR   = 6'd7;
  localparam logic [5:0] TK_PCT    = 6'd8;
  localparam logic [5:0] TK_SEMI   = 6'd9;
  localparam logic [5:0] TK_DOT    = 6'd10;
  localparam logic [5:0] TK_COMMA  = 6'd11;
  localparam logic [5:0] TK_OPBASE = 6'd12;
  localparam logic [5:0] TK_SLASH  = 6'd20;
  localparam logic [5:0] TK_STRING = 6'd21;
  localparam logic [5:0] TK_NUMBER = 6'd22;
  localparam logic [5:0] TK_IDENT  = 6'd23;
  localparam logic [5:0] TK_ELSE   = 6'd24;
  localparam logic [5:0] TK_MUT    = 6'd25;
  localparam logic [5:0] TK_NIL    = 6'd26;
  localparam logic [5:0] TK_PURE   = 6'd27;
  localparam logic [5:0] TK_RETURN = 6'd28;
  localparam logic [5:0] TK_TRUE   = 6'd29;
  localparam logic [5:0] TK_WHILE  = 6'd30;
  localparam logic [5:0] TK_FN     = 6'd31;
  localparam logic [5:0] TK_FALSE  = 6'd32;
  localparam logic [5:0] TK_IF     = 6'd33;
  localparam logic [5:0] TK_IMUT   = 6'd34;
  localparam logic [5:0] TK_IMPURE = 6'd35;
  localparam logic [5:0] TK_ERROR  = 6'd36;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_BYTE  = 2'd1;
  localparam logic [1:0] ERR_STRNG = 2'd2;

  localparam logic [1:0] OP_BANG = 2'd0;
  localparam logic [1:0] OP_EQ   = 2'd1;
  localparam logic [1:0] OP_LT   = 2'd2;
  localparam logic [1:0] OP_GT   = 2'd3;

  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

  // One token as it leaves the lexer.
  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [23:0] line;
    logic [31:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  // Up to three tokens caused by one byte.
  typedef struct packed {
    logic [1:0] count;
    token_t     t0;
    token_t     t1;
    token_t     t2;
  } tok_group_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
           (b == 8'h5F);
  endfunction

  // Single-byte punctuators; TK_EOF if not one.
  function automatic logic [5:0] punct_kind(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      8'h28:   k = TK_LPAR;
      8'h29:   k = TK_RPAR;
      8'h7B:   k = TK_LBRACE;
      8'h7D:   k = TK_RBRACE;
      8'h2B:   k = TK_PLUS;
      8'h2D:   k = TK_MINUS;
      8'h2A:   k = TK_STAR;
      8'h25:   k = TK_PCT;
      8'h3B:   k = TK_SEMI;
      8'h2C:   k = TK_COMMA;
      default: k = TK_EOF;
    endcase
    return k;
  endfunction

endpackage

/* hdl/sbl_if.sv */
// Valid/ready channel interfaces for bytes in and tokens out.
interface sbl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_source;
  modport source (output valid, source_byte, end_of_source, input ready);
  modport sink (input valid, source_byte, end_of_source, output ready);
endinterface

interface sbl_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [1:0]  error_kind;
  logic [23:0] line_number;
  logic [31:0] start_offset;
  logic [15:0] token_length;
  logic        last_of_run;
  modport source (output valid, token_kind, error_kind, line_number, start_offset,
                  token_length, last_of_run, input ready);
  modport sink (input valid, token_kind, error_kind, line_number, start_offset,
                token_length, last_of_run, output ready);
endinterface

/* hdl/source_byte_lexer.sv */
// Top level of the source byte lexer.
// Byte stream in on in_* (source_byte, end_of_source), tokens out on out_*.
// One byte is taken per cycle while the group queue has room
// (in_ready follows grp_ready), so the sustained rate is one byte per
// cycle while the receiver keeps up. A byte may give up to three tokens;
// these leave one per beat. A byte's tokens pass through the scan register,
// then the group queue. Tokens for the held lookahead appear when the next
// byte or the end marker arrives; last_of_run flags the last token of a byte.
// When the receiver stalls, the two-entry group queue fills and then
// in_ready drops; nothing is lost. Synchronous reset puts the lexer in
// its idle mode at line 1, offset 0, with the queue empty. An end marker
// also returns the scan state to that point after its end token.
module source_byte_lexer #(
  parameter int KEYWORD_PREFIX_BYTES = 6,
  parameter int LENGTH_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  sbl_in_if.sink    in_ch,
  sbl_out_if.source out_ch
);
  import sbl_pkg::*;

  logic       grp_valid, grp_ready;
  tok_group_t grp;
  token_t     tok;

  sbl_scan #(
    .KEYWORD_PREFIX_BYTES(KEYWORD_PREFIX_BYTES),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_scan (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_byte(in_ch.source_byte), .in_eos(in_ch.end_of_source),
    .grp_ready(grp_ready), .in_ready(in_ch.ready),
    .grp_valid(grp_valid), .grp(grp)
  );

  sbl_emit u_emit (
    .clk(clk), .rst_n(rst_n),
    .grp_valid(grp_valid), .grp(grp), .grp_ready(grp_ready),
    .tok_valid(out_ch.valid), .tok(tok), .tok_ready(out_ch.ready)
  );

  assign out_ch.token_kind = tok.kind;
  assign out_ch.error_kind = tok.err;
  assign out_ch.line_number = tok.line;
  assign out_ch.start_offset = tok.start;
  assign out_ch.token_length = tok.len;
  assign out_ch.last_of_run = tok.last;
endmodule

/* hdl/sbl_scan.sv */
// Front end: scans one byte per cycle while grp_ready is high and produces a group of tokens.
module sbl_scan #(
  parameter int KEYWORD_PREFIX_BYTES = 6,
  parameter int LENGTH_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  input  logic               in_eos,
  input  logic               grp_ready,
  output logic               in_ready,
  output logic               grp_valid,
  output sbl_pkg::tok_group_t grp
);
  import sbl_pkg::*;

  localparam int PB = (KEYWORD_PREFIX_BYTES > 1) ? $clog2(KEYWORD_PREFIX_BYTES) : 1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  lex_mode_t              mode_r, mode_nxt;
  logic [1:0]             pop_r, pop_nxt;
  logic [23:0]            line_r, line_nxt;
  logic [31:0]            pos_r, pos_nxt;
  logic [31:0]            start_r, start_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [7:0]             pfx_r [KEYWORD_PREFIX_BYTES];
  logic                   pfx_we;
  logic [PB-1:0]          pfx_idx;

  logic       fire;
  logic [5:0] kw;
  logic [15:0] len_out;
  token_t     q [3];
  logic [1:0] n;

  assign in_ready = grp_ready;
  assign fire = in_valid && in_ready;
  assign len_out = (len_r > LENGTH_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(len_r);

  function automatic logic [LENGTH_BITS-1:0] sat(input logic [LENGTH_BITS-1:0] a,
                                                 input logic [1:0] d);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, a} + (LENGTH_BITS+1)'(d);
    return s[LENGTH_BITS] ? LEN_MAX : s[LENGTH_BITS-1:0];
  endfunction

  // Exact keyword match against the stored prefix; w holds nb bytes, first byte highest.
  function automatic logic pm(input logic [47:0] w, input logic [2:0] nb);
    logic ok;
    ok = (len_r == LENGTH_BITS'(nb));
    for (int i = 0; i < 6; i++)
      if (i < int'(nb)) ok = ok && (pfx_r[i] == w[8*(int'(nb)-1-i) +: 8]);
    return ok;
  endfunction

  always_comb begin
    kw = TK_IDENT;
    if (pm("else", 3'd4)) kw = TK_ELSE;
    else if (pm("mut", 3'd3)) kw = TK_MUT;
    else if (pm("nil", 3'd3)) kw = TK_NIL;
    else if (pm("pure", 3'd4)) kw = TK_PURE;
    else if (pm("return", 3'd6)) kw = TK_RETURN;
    else if (pm("true", 3'd4)) kw = TK_TRUE;
    else if (pm("while", 3'd5)) kw = TK_WHILE;
    else if (pm("fn", 3'd2)) kw = TK_FN;
    else if (pm("false", 3'd5)) kw = TK_FALSE;
    else if (pm("if", 3'd2)) kw = TK_IF;
    else if (pm("imut", 3'd4)) kw = TK_IMUT;
    else if (pm("impure", 3'd6)) kw = TK_IMPURE;
  end

  always_comb begin
    logic held, rescan;
    logic [7:0] b;
    logic [5:0] pk;
    b = in_byte;
    mode_nxt = mode_r;
    pop_nxt = pop_r;
    line_nxt = line_r;
    pos_nxt = pos_r;
    start_nxt = start_r;
    len_nxt = len_r;
    pfx_we = 1'b0;
    pfx_idx = '0;
    n = 2'd0;
    held = 1'b0;
    rescan = 1'b0;
    pk = punct_kind(b);
    for (int i = 0; i < 3; i++) q[i] = '0;

    if (in_eos) begin
      held = 1'b1;
    end else begin
      pos_nxt = pos_r + 32'd1;
      case (mode_r)
        M_SLASH:  if (b == 8'h2F) mode_nxt = M_COMMENT; else begin held = 1'b1; rescan = 1'b1; end
        M_OP: begin
          if (b == 8'h3D) begin
            q[0] = '{TK_OPBASE + 6'd1 + {3'd0, pop_r, 1'b0}, ERR_NONE, line_r, start_r, 16'd2, 1'b0};
            n = 2'd1;
            mode_nxt = M_IDLE;
          end else begin held = 1'b1; rescan = 1'b1; end
        end
        M_DOT: begin
          if (is_digit(b)) begin mode_nxt = M_FRAC; len_nxt = sat(len_r, 2'd1); end
          else begin held = 1'b1; rescan = 1'b1; end
        end
        M_INT: begin
          if (is_digit(b)) len_nxt = sat(len_r, 2'd1);
          else if (b == 8'h2E) mode_nxt = M_NUMDOT;
          else begin held = 1'b1; rescan = 1'b1; end
        end
        M_NUMDOT: begin
          if (is_digit(b)) begin mode_nxt = M_FRAC; len_nxt = sat(len_r, 2'd2); end
          else begin held = 1'b1; rescan = 1'b1; end
        end
        M_FRAC: begin
          if (is_digit(b)) len_nxt = sat(len_r, 2'd1);
          else begin held = 1'b1; rescan = 1'b1; end
        end
        M_IDENT: begin
          if (is_alpha(b) || is_digit(b)) begin
            if (len_r < LENGTH_BITS'(KEYWORD_PREFIX_BYTES)) begin
              pfx_we = 1'b1;
              pfx_idx = PB'(len_r);
            end
            len_nxt = sat(len_r, 2'd1);
          end else begin held = 1'b1; rescan = 1'b1; end
        end
        M_STRING: begin
          len_nxt = sat(len_r, 2'd1);
          if (b == 8'h0A && line_r < LINE_MAX) line_nxt = line_r + 24'd1;
          if (b == 8'h22) begin
            q[0] = '{TK_STRING, ERR_NONE, line_nxt, start_r,
                     (len_nxt > LENGTH_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(len_nxt), 1'b0};
            n = 2'd1;
            mode_nxt = M_IDLE;
          end
        end
        M_COMMENT: if (b == 8'h0A) rescan = 1'b1;
        default:   rescan = 1'b1;
      endcase
    end

    // Token held by the current mode (also the unterminated string at end).
    if (held) begin
      case (mode_r)
        M_SLASH: begin q[0] = '{TK_SLASH, ERR_NONE, line_r, start_r, 16'd1, 1'b0}; n = 2'd1; end
        M_OP: begin
          q[0] = '{TK_OPBASE + {3'd0, pop_r, 1'b0}, ERR_NONE, line_r, start_r, 16'd1, 1'b0};
          n = 2'd1;
        end
        M_DOT: begin q[0] = '{TK_DOT, ERR_NONE, line_r, start_r, 16'd1, 1'b0}; n = 2'd1; end
        M_INT, M_FRAC: begin
          q[0] = '{TK_NUMBER, ERR_NONE, line_r, start_r, len_out, 1'b0}; n = 2'd1;
        end
        M_NUMDOT: begin
          q[0] = '{TK_NUMBER, ERR_NONE, line_r, start_r, len_out, 1'b0};
          q[1] = '{TK_DOT, ERR_NONE, line_r, pos_r - 32'd1, 16'd1, 1'b0};
          n = 2'd2;
        end
        M_IDENT: begin q[0] = '{kw, ERR_NONE, line_r, start_r, len_out, 1'b0}; n = 2'd1; end
        M_STRING: begin
          q[0] = '{TK_ERROR, ERR_STRNG, line_r, start_r, len_out, 1'b0}; n = 2'd1;
        end
        default: ;
      endcase
    end

    if (rescan) begin
      mode_nxt = M_IDLE;
      if (b == 8'h0A) begin
        if (line_r < LINE_MAX) line_nxt = line_r + 24'd1;
      end else if (b == 8'h20 || b == 8'h0D || b == 8'h09) begin
      end else if (pk != TK_EOF) begin
        q[n] = '{pk, ERR_NONE, line_r, pos_r, 16'd1, 1'b0}; n = n + 2'd1;
      end else if (b == 8'h21 || b == 8'h3D || b == 8'h3C || b == 8'h3E) begin
        mode_nxt = M_OP;
        pop_nxt = (b == 8'h21) ? OP_BANG : (b == 8'h3D) ? OP_EQ : (b == 8'h3C) ? OP_LT : OP_GT;
        start_nxt = pos_r; len_nxt = LENGTH_BITS'(1);
      end else if (b == 8'h2F || b == 8'h2E || b == 8'h22 || is_digit(b) || is_alpha(b)) begin
        mode_nxt = (b == 8'h2F) ? M_SLASH : (b == 8'h2E) ? M_DOT : (b == 8'h22) ? M_STRING :
                   is_digit(b) ? M_INT : M_IDENT;
        start_nxt = pos_r; len_nxt = LENGTH_BITS'(1);
        if (is_alpha(b)) begin pfx_we = 1'b1; pfx_idx = '0; end
      end else begin
        q[n] = '{TK_ERROR, ERR_BYTE, line_r, pos_r, 16'd1, 1'b0}; n = n + 2'd1;
      end
    end

    if (in_eos) begin
      q[n] = '{TK_EOF, ERR_NONE, line_r, pos_r, 16'd0, 1'b0};
      n = n + 2'd1;
      mode_nxt = M_IDLE; pop_nxt = OP_BANG; line_nxt = 24'd1;
      pos_nxt = '0; start_nxt = '0; len_nxt = '0;
    end
    if (n != 2'd0) q[n - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pop_r <= OP_BANG;
      line_r <= 24'd1;
      pos_r <= '0;
      start_r <= '0;
      len_r <= '0;
      grp_valid <= 1'b0;
    end else begin
      if (grp_ready) grp_valid <= fire && (n != 2'd0);
      if (fire) begin
        mode_r <= mode_nxt;
        pop_r <= pop_nxt;
        line_r <= line_nxt;
        pos_r <= pos_nxt;
        start_r <= start_nxt;
        len_r <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pfx_we) pfx_r[pfx_idx] <= in_byte;
    if (grp_ready) grp <= '{n, q[0], q[1], q[2]};
  end
endmodule

/* hdl/sbl_emit.sv */
// Back end: queues token groups and sends them out one token per beat.
module sbl_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                grp_valid,
  input  sbl_pkg::tok_group_t grp,
  output logic                grp_ready,
  output logic                tok_valid,
  output sbl_pkg::token_t     tok,
  input  logic                tok_ready
);
  import sbl_pkg::*;

  // Two-entry group queue.
  tok_group_t qd_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic       push, pop;
  tok_group_t hd;

  assign hd = qd_r[rp_r];
  assign grp_ready = (cnt_r != 2'd2);
  assign push = grp_valid && grp_ready;
  assign tok_valid = (cnt_r != 2'd0);

  always_comb begin
    case (sub_r)
      2'd0:    tok = hd.t0;
      2'd1:    tok = hd.t1;
      default: tok = hd.t2;
    endcase
    pop = 1'b0;
    sub_nxt = sub_r;
    if (tok_valid && tok_ready) begin
      if (sub_r + 2'd1 == hd.count) begin pop = 1'b1; sub_nxt = 2'd0; end
      else sub_nxt = sub_r + 2'd1;
    end
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
      sub_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
      sub_r <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) qd_r[wp_r] <= grp;
  end
endmodule

/* test/tb_top.sv */
// Self-checking testbench for source_byte_lexer: directed table, then random source text.
`timescale 1ns / 100ps

module tb_top;
  import sbl_pkg::*;

  localparam int unsigned LEN_SAT = 65535;
  localparam int          WDOG_LIMIT = 5000;
  localparam int          PREFIX_N = 6;
  localparam int          N_ITEMS = 480;

  typedef struct {
    logic [7:0] b;
    bit         eos;
  } src_beat_t;

  typedef struct {
    logic [7:0]  b;
    bit          eos;
    bit          chk;
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [31:0] start;
    logic [15:0] len;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sbl_in_if  in_ch();
  sbl_out_if out_ch();

  source_byte_lexer dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Lexer shadow state
  lex_mode_t   sh_mode;
  logic [1:0]  sh_pend;
  logic [23:0] sh_line;
  logic [31:0] sh_pos;
  logic [31:0] sh_tstart;
  int unsigned sh_tlen;
  logic [7:0]  sh_prefix [PREFIX_N];

  token_t      step_toks[$];
  token_t      tokens_due[$];
  src_beat_t   src_beats[$];
  dir_row_t    dir_rows[$];
  string       kw_text[12] = '{"else", "mut", "nil", "pure", "return", "true", "while",
                               "fn", "false", "if", "imut", "impure"};

  int  n_fail = 0;
  int  n_tokens = 0;
  int  n_eof = 0;
  int  n_dir = 0;
  int  cyc = 0;
  int  wdog = 0;
  bit  in_done = 0;

  function automatic bit chr_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit chr_word(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic int unsigned len_add(int unsigned a, int unsigned n);
    return (a + n > LEN_SAT) ? LEN_SAT : a + n;
  endfunction

  function automatic void lex_clear();
    sh_mode = M_IDLE;
    sh_pend = OP_BANG;
    sh_line = 24'd1;
    sh_pos = '0;
    sh_tstart = '0;
    sh_tlen = 0;
    foreach (sh_prefix[i]) sh_prefix[i] = '0;
  endfunction

  function automatic void tok_push(logic [5:0] k, logic [1:0] e, logic [31:0] s,
                                   int unsigned n);
    token_t t;
    t.kind = k;
    t.err = e;
    t.line = sh_line;
    t.start = s;
    t.len = (n > LEN_SAT) ? 16'hFFFF : n[15:0];
    t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic logic [5:0] word_kind();
    int n;
    bit hit;
    for (int i = 0; i < 12; i++) begin
      n = kw_text[i].len();
      if (sh_tlen == n && n <= PREFIX_N) begin
        hit = 1;
        for (int j = 0; j < n; j++)
          if (sh_prefix[j] != kw_text[i][j]) hit = 0;
        if (hit) return TK_ELSE + 6'(i);
      end
    end
    return TK_IDENT;
  endfunction

  function automatic void open_tok(lex_mode_t m);
    sh_mode = m;
    sh_tstart = sh_pos;
    sh_tlen = 1;
  endfunction

  function automatic void scan_fresh(logic [7:0] b);
    sh_mode = M_IDLE;
    case (b)
      " ", "\r", "\t": ;
      "\n": if (sh_line != LINE_MAX) sh_line++;
      "(": tok_push(TK_LPAR, ERR_NONE, sh_pos, 1);
      ")": tok_push(TK_RPAR, ERR_NONE, sh_pos, 1);
      "{": tok_push(TK_LBRACE, ERR_NONE, sh_pos, 1);
      "}": tok_push(TK_RBRACE, ERR_NONE, sh_pos, 1);
      "+": tok_push(TK_PLUS, ERR_NONE, sh_pos, 1);
      "-": tok_push(TK_MINUS, ERR_NONE, sh_pos, 1);
      "*": tok_push(TK_STAR, ERR_NONE, sh_pos, 1);
      "%": tok_push(TK_PCT, ERR_NONE, sh_pos, 1);
      ";": tok_push(TK_SEMI, ERR_NONE, sh_pos, 1);
      ",": tok_push(TK_COMMA, ERR_NONE, sh_pos, 1);
      "!": begin sh_pend = OP_BANG; open_tok(M_OP); end
      "=": begin sh_pend = OP_EQ; open_tok(M_OP); end
      "<": begin sh_pend = OP_LT; open_tok(M_OP); end
      ">": begin sh_pend = OP_GT; open_tok(M_OP); end
      "/": open_tok(M_SLASH);
      ".": open_tok(M_DOT);
      "\"": open_tok(M_STRING);
      default: begin
        if (chr_digit(b)) open_tok(M_INT);
        else if (chr_word(b)) begin
          open_tok(M_IDENT);
          sh_prefix[0] = b;
        end else tok_push(TK_ERROR, ERR_BYTE, sh_pos, 1);
      end
    endcase
  endfunction

  function automatic void flush_pending();
    case (sh_mode)
      M_SLASH:  tok_push(TK_SLASH, ERR_NONE, sh_tstart, 1);
      M_OP:     tok_push(TK_OPBASE + {3'd0, sh_pend, 1'b0}, ERR_NONE, sh_tstart, 1);
      M_DOT:    tok_push(TK_DOT, ERR_NONE, sh_tstart, 1);
      M_INT, M_FRAC: tok_push(TK_NUMBER, ERR_NONE, sh_tstart, sh_tlen);
      M_NUMDOT: begin
        tok_push(TK_NUMBER, ERR_NONE, sh_tstart, sh_tlen);
        tok_push(TK_DOT, ERR_NONE, sh_pos - 32'd1, 1);
      end
      M_IDENT:  tok_push(word_kind(), ERR_NONE, sh_tstart, sh_tlen);
      default: ;
    endcase
  endfunction

  // One accepted beat: tokens land in step_toks, then on tokens_due.
  function automatic void lex_beat(logic [7:0] b, bit eos);
    step_toks.delete();
    if (eos) begin
      if (sh_mode == M_STRING) tok_push(TK_ERROR, ERR_STRNG, sh_tstart, sh_tlen);
      else flush_pending();
      tok_push(TK_EOF, ERR_NONE, sh_pos, 0);
      lex_clear();
    end else begin
      case (sh_mode)
        M_SLASH:
          if (b == "/") sh_mode = M_COMMENT;
          else begin flush_pending(); scan_fresh(b); end
        M_OP:
          if (b == "=") begin
            tok_push(TK_OPBASE + 6'd1 + {3'd0, sh_pend, 1'b0}, ERR_NONE, sh_tstart, 2);
            sh_mode = M_IDLE;
          end else begin flush_pending(); scan_fresh(b); end
        M_DOT:
          if (chr_digit(b)) begin
            sh_mode = M_FRAC;
            sh_tlen = len_add(sh_tlen, 1);
          end else begin flush_pending(); scan_fresh(b); end
        M_INT:
          if (chr_digit(b)) sh_tlen = len_add(sh_tlen, 1);
          else if (b == ".") sh_mode = M_NUMDOT;
          else begin flush_pending(); scan_fresh(b); end
        M_NUMDOT:
          if (chr_digit(b)) begin
            sh_mode = M_FRAC;
            sh_tlen = len_add(sh_tlen, 2);
          end else begin flush_pending(); scan_fresh(b); end
        M_FRAC:
          if (chr_digit(b)) sh_tlen = len_add(sh_tlen, 1);
          else begin flush_pending(); scan_fresh(b); end
        M_IDENT:
          if (chr_word(b) || chr_digit(b)) begin
            if (sh_tlen < PREFIX_N) sh_prefix[sh_tlen] = b;
            sh_tlen = len_add(sh_tlen, 1);
          end else begin flush_pending(); scan_fresh(b); end
        M_STRING: begin
          sh_tlen = len_add(sh_tlen, 1);
          if (b == "\n" && sh_line != LINE_MAX) sh_line++;
          if (b == "\"") begin
            tok_push(TK_STRING, ERR_NONE, sh_tstart, sh_tlen);
            sh_mode = M_IDLE;
          end
        end
        M_COMMENT: if (b == "\n") scan_fresh(b);
        default: scan_fresh(b);
      endcase
      sh_pos++;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
  endfunction

  function automatic void add_row(logic [7:0] b, bit eos, bit chk = 0,
                                  logic [5:0] k = TK_EOF, logic [1:0] e = ERR_NONE,
                                  logic [31:0] s = 0, logic [15:0] n = 0);
    dir_row_t r;
    r = '{b, eos, chk, k, e, s, n};
    dir_rows.push_back(r);
  endfunction

  function automatic void put_byte(logic [7:0] b, bit eos = 0);
    src_beat_t sb;
    sb.b = b;
    sb.eos = eos;
    src_beats.push_back(sb);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic logic [7:0] any_word_chr(bit digits_ok);
    string pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    return pool[$urandom_range(0, digits_ok ? 62 : 52)];
  endfunction

  function automatic void put_fragment();
    string ops = "(){}+-*%;,!=<>/.";
    string blanks = " \t\r\n";
    int n;
    case ($urandom_range(0, 11))
      0, 1: put_text(kw_text[$urandom_range(0, 11)]);
      2: begin
        n = $urandom_range(1, 9);
        put_byte(any_word_chr(0));
        for (int i = 1; i < n; i++) put_byte(any_word_chr(1));
      end
      3: begin
        if ($urandom_range(0, 3) == 0) put_byte(".");
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) put_byte(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 1)) begin
          put_byte(".");
          if ($urandom_range(0, 1)) put_byte(8'("0" + $urandom_range(0, 9)));
        end
      end
      4: begin
        put_byte(ops[$urandom_range(0, 15)]);
        if ($urandom_range(0, 1)) put_byte("=");
      end
      5: begin
        put_byte("\"");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
          put_byte($urandom_range(0, 3) == 0 ? 8'h0A : 8'($urandom_range(32, 126)));
        if ($urandom_range(0, 5) != 0) put_byte("\"");
      end
      6: begin
        put_text("//");
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
        put_byte("\n");
      end
      7, 8: put_byte(blanks[$urandom_range(0, 3)]);
      9: put_byte(8'($urandom_range(0, 255)));
      10: put_byte(ops[$urandom_range(0, 15)]);
      default: if ($urandom_range(0, 2) == 0) put_byte(8'($urandom_range(0, 255)), 1);
    endcase
    if ($urandom_range(0, 1)) put_byte(blanks[$urandom_range(0, 3)]);
  endfunction

  function automatic bit quiet_span();
    return cyc >= 300 && cyc < 900;
  endfunction

  // Input side: present one beat at a time, hold it until taken.
  initial begin : drive_bytes
    int idx;
    src_beat_t cur;
    idx = 0;
    in_ch.valid = 1'b0;
    in_ch.source_byte = '0;
    in_ch.end_of_source = 1'b0;

    add_row(8'h00, 0, 1, TK_ERROR, ERR_BYTE, 0, 1);
    add_row("(", 0, 1, TK_LPAR, ERR_NONE, 1, 1);
    add_row("!", 0);
    add_row("=", 0, 1, TK_OPBASE + 6'd1, ERR_NONE, 2, 2);
    add_row(8'hFF, 0, 1, TK_ERROR, ERR_BYTE, 4, 1);
    add_row("1", 0);
    add_row(".", 0);
    add_row("x", 0, 1, TK_NUMBER, ERR_NONE, 5, 1);
    add_row(" ", 0, 1, TK_IDENT, ERR_NONE, 7, 1);
    add_row("f", 0);
    add_row("n", 0);
    add_row(";", 0, 1, TK_FN, ERR_NONE, 9, 2);
    add_row("/", 0);
    add_row("/", 0);
    add_row("c", 0);
    add_row("\n", 0);
    add_row("/", 0);
    add_row(" ", 0, 1, TK_SLASH, ERR_NONE, 16, 1);
    add_row("\"", 0);
    add_row("a", 0);
    add_row(8'h00, 1, 1, TK_ERROR, ERR_STRNG, 18, 2);
    add_row(8'h55, 1, 1, TK_EOF, ERR_NONE, 0, 0);
    foreach (dir_rows[i]) put_byte(dir_rows[i].b, dir_rows[i].eos);
    n_dir = dir_rows.size();

    while (src_beats.size() < N_ITEMS - 1) put_fragment();
    put_byte(8'h00, 1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    lex_clear();

    forever begin
      @(posedge clk);
      if (in_ch.valid && in_ch.ready) begin
        lex_beat(cur.b, cur.eos);
        if (cur.eos) n_eof++;
        if (idx <= n_dir && dir_rows[idx - 1].chk) begin
          if (step_toks.size() == 0) begin
            $error("directed row %0d: no token predicted", idx - 1);
            n_fail++;
          end else begin
            if (step_toks[0].kind != dir_rows[idx - 1].kind) begin
              $error("directed row %0d: token_kind exp %0d got %0d",
                     idx - 1, dir_rows[idx - 1].kind, step_toks[0].kind);
              n_fail++;
            end
            if (step_toks[0].err != dir_rows[idx - 1].err) begin
              $error("directed row %0d: error_kind exp %0d got %0d",
                     idx - 1, dir_rows[idx - 1].err, step_toks[0].err);
              n_fail++;
            end
            if (step_toks[0].start != dir_rows[idx - 1].start) begin
              $error("directed row %0d: start_offset exp %0d got %0d",
                     idx - 1, dir_rows[idx - 1].start, step_toks[0].start);
              n_fail++;
            end
            if (step_toks[0].len != dir_rows[idx - 1].len) begin
              $error("directed row %0d: token_length exp %0d got %0d",
                     idx - 1, dir_rows[idx - 1].len, step_toks[0].len);
              n_fail++;
            end
          end
        end
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold current beat
      end else if (idx < src_beats.size() &&
                   (quiet_span() || $urandom_range(0, 99) >= 22)) begin
        cur = src_beats[idx];
        idx++;
        in_ch.valid <= 1'b1;
        in_ch.source_byte <= cur.b;
        in_ch.end_of_source <= cur.eos;
      end else begin
        in_ch.valid <= 1'b0;
        if (idx >= src_beats.size()) in_done = 1;
      end
    end
  end

  // Output side: random back-pressure, compare each token beat.
  initial begin : check_tokens
    token_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (tokens_due.size() == 0) begin
          $error("unexpected token beat: kind %0d start %0d",
                 out_ch.token_kind, out_ch.start_offset);
          n_fail++;
        end else begin
          want = tokens_due.pop_front();
          n_tokens++;
          if (out_ch.token_kind !== want.kind) begin
            $error("token_kind exp %0d got %0d", want.kind, out_ch.token_kind); n_fail++;
          end
          if (out_ch.error_kind !== want.err) begin
            $error("error_kind exp %0d got %0d", want.err, out_ch.error_kind); n_fail++;
          end
          if (out_ch.line_number !== want.line) begin
            $error("line_number exp %0d got %0d", want.line, out_ch.line_number); n_fail++;
          end
          if (out_ch.start_offset !== want.start) begin
            $error("start_offset exp %0d got %0d", want.start, out_ch.start_offset);
            n_fail++;
          end
          if (out_ch.token_length !== want.len) begin
            $error("token_length exp %0d got %0d", want.len, out_ch.token_length);
            n_fail++;
          end
          if (out_ch.last_of_run !== want.last) begin
            $error("last_of_run exp %0d got %0d", want.last, out_ch.last_of_run);
            n_fail++;
          end
        end
      end
      out_ch.ready <= rst_n && (quiet_span() || $urandom_range(0, 99) >= 22);
    end
  end

  // Watchdog on cycles with no beat on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : finish_run
    wait (in_done);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tokens_due.size() != 0) begin
      $error("%0d tokens never arrived", tokens_due.size());
      n_fail++;
    end
    $display("%0d source beats (directed table of %0d), %0d tokens checked, %0d end markers,",
             src_beats.size(), n_dir, n_tokens, n_eof);
    $display("keywords, numbers, operators, strings, comments and stray bytes under back-pressure");
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
